// ===== sv/mtdf_pkg.sv =====
// Shared types, widths and register codes for the DShot framer.
// No dependencies; imported by mtdf_core and the top level.
package mtdf_pkg;

  localparam int MOTOR_COUNT_DEFAULT = 2;

  localparam int ThrW     = 11;
  localparam int CmdW     = 17;
  localparam int MagW     = 16;
  localparam int DeltaW   = 12;
  localparam int SumW     = 13;
  localparam int FrameW   = 16;
  localparam int MotorW   = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam logic [ThrW-1:0] MAX_DELTA_RST    = 11'd100;
  localparam logic [ThrW-1:0] MIN_THROTTLE_RST = 11'd48;
  localparam logic [ThrW-1:0] MAX_THROTTLE_RST = 11'd2047;

  // Q1.15 full scale
  localparam logic [MagW-1:0] FULL_SCALE = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DELTA    = 2'd0,
    REG_MIN_THROTTLE = 2'd1,
    REG_MAX_THROTTLE = 2'd2,
    REG_TELEMETRY    = 2'd3
  } mtdf_reg_t;

  typedef enum logic {
    ACT_CONTROL = 1'b0,
    ACT_RAW     = 1'b1
  } mtdf_action_t;

  typedef struct packed {
    logic [ThrW-1:0] max_delta;
    logic [ThrW-1:0] min_throttle;
    logic [ThrW-1:0] max_throttle;
    logic            telemetry;
  } mtdf_cfg_t;

  // payload = value:telemetry, checksum = xor of the three nibbles
  function automatic logic [FrameW-1:0] build_frame(input logic [ThrW-1:0] value,
                                                     input logic            tlm);
    logic [11:0] payload;
    logic [3:0]  csum;
    payload = {value, tlm};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, csum};
  endfunction

endpackage

// ===== sv/motor_throttle_dshot_framer_unit.sv =====
// Top level of the per-motor DShot framer: input register, throttle store,
// result register. Depends on mtdf_pkg and mtdf_core.
//
// Input channel (in_valid/in_stall) takes one beat per cycle while in_stall
// is low: action, motor, control_cmd and raw_value. Action 0 adds a scaled
// signed Q2.15 command to the motor's stored throttle; action 1 sends
// raw_value without touching it. Output channel (out_valid/out_stall) carries
// out_motor, the 16-bit frame and sent_value. A beat for a motor index at or
// above MOTOR_COUNT is dropped. A taken beat is registered in the input
// register; the result register loads from it as the throttle store is
// updated, so back-to-back beats to one motor see the updated value. One
// beat moves on per cycle while the receiver does not stall. When it stalls,
// the result holds and one more beat can wait in the input register;
// in_stall rises only once both are full. Reset clears both valid flags,
// sets all throttles to zero and loads the register defaults. The user must
// write the config port (cfg_write/cfg_index/cfg_data) only while idle; the
// block itself does not enforce it.
module motor_throttle_dshot_framer_unit #(
  parameter int MOTOR_COUNT = mtdf_pkg::MOTOR_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic        [mtdf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic        [mtdf_pkg::CfgDataW-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic        [mtdf_pkg::MotorW-1:0]   motor,
  input  logic signed [mtdf_pkg::CmdW-1:0]     control_cmd,
  input  logic        [mtdf_pkg::ThrW-1:0]     raw_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [mtdf_pkg::MotorW-1:0]   out_motor,
  output logic        [mtdf_pkg::FrameW-1:0]   frame,
  output logic        [mtdf_pkg::ThrW-1:0]     sent_value
);
  import mtdf_pkg::*;

  localparam int IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [MotorW:0] MotorLimit = (MotorW + 1)'(MOTOR_COUNT);

  mtdf_cfg_t cfg;

  logic [ThrW-1:0] motor_throttle [MOTOR_COUNT];

  logic                     s1_valid;
  logic                     s1_action;
  logic [MotorW-1:0]        s1_motor;
  logic signed [CmdW-1:0]   s1_cmd;
  logic [ThrW-1:0]          s1_raw;

  logic                     advance;
  logic                     in_range;
  logic [IdxW-1:0]          s1_idx;
  logic [ThrW-1:0]          throttle_next;
  logic [ThrW-1:0]          value_next;
  logic [FrameW-1:0]        frame_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_range = {1'b0, s1_motor} < MotorLimit;
  assign s1_idx   = s1_motor[IdxW-1:0];

  mtdf_core u_core (
    .cfg           (cfg),
    .action        (s1_action),
    .control_cmd   (s1_cmd),
    .raw_value     (s1_raw),
    .throttle      (motor_throttle[s1_idx]),
    .throttle_next (throttle_next),
    .sent_value    (value_next),
    .frame         (frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_delta    <= MAX_DELTA_RST;
      cfg.min_throttle <= MIN_THROTTLE_RST;
      cfg.max_throttle <= MAX_THROTTLE_RST;
      cfg.telemetry    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_DELTA:    cfg.max_delta    <= cfg_data[ThrW-1:0];
        REG_MIN_THROTTLE: cfg.min_throttle <= cfg_data[ThrW-1:0];
        REG_MAX_THROTTLE: cfg.max_throttle <= cfg_data[ThrW-1:0];
        REG_TELEMETRY:    cfg.telemetry    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_throttle[i] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid && in_range;
      end
      if (advance && s1_valid && in_range && s1_action == ACT_CONTROL) begin
        motor_throttle[s1_idx] <= throttle_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_motor  <= motor;
      s1_cmd    <= control_cmd;
      s1_raw    <= raw_value;
    end
    if (advance && s1_valid) begin
      out_motor  <= s1_motor;
      frame      <= frame_next;
      sent_value <= value_next;
    end
  end

endmodule

// ===== sv/mtdf_core.sv =====
// Throttle arithmetic and frame build for one beat: command scaling,
// throttle rules, clamp and checksum. Depends on mtdf_pkg.
module mtdf_core (
  input  mtdf_pkg::mtdf_cfg_t                 cfg,
  input  logic                                action,
  input  logic signed [mtdf_pkg::CmdW-1:0]    control_cmd,
  input  logic        [mtdf_pkg::ThrW-1:0]    raw_value,
  input  logic        [mtdf_pkg::ThrW-1:0]    throttle,
  output logic        [mtdf_pkg::ThrW-1:0]    throttle_next,
  output logic        [mtdf_pkg::ThrW-1:0]    sent_value,
  output logic        [mtdf_pkg::FrameW-1:0]  frame
);
  import mtdf_pkg::*;

  localparam int ProdW = MagW + ThrW;

  logic                    neg;
  logic [MagW-1:0]         mag;
  logic [ProdW-1:0]        prod;
  logic [DeltaW-1:0]       delta;
  logic signed [SumW-1:0]  sum;
  logic [ThrW-1:0]         value;

  always_comb begin
    neg = control_cmd[CmdW-1];
    if (neg) begin
      if (control_cmd < -$signed({1'b0, FULL_SCALE})) begin
        mag = FULL_SCALE;
      end else begin
        mag = MagW'(-control_cmd);
      end
    end else begin
      if (control_cmd > $signed({1'b0, FULL_SCALE})) begin
        mag = FULL_SCALE;
      end else begin
        mag = control_cmd[MagW-1:0];
      end
    end

    prod  = ProdW'(mag) * ProdW'(cfg.max_delta);
    delta = prod[ProdW-1:15];

    if (neg) begin
      sum = $signed({2'b00, throttle}) - $signed({1'b0, delta});
    end else begin
      sum = $signed({2'b00, throttle}) + $signed({1'b0, delta});
    end

    if (sum <= 0) begin
      throttle_next = '0;
    end else if (sum < $signed({2'b00, cfg.min_throttle})) begin
      throttle_next = cfg.min_throttle;
    end else if (sum > $signed({2'b00, cfg.max_throttle})) begin
      throttle_next = cfg.max_throttle;
    end else begin
      throttle_next = sum[ThrW-1:0];
    end

    value = (action == ACT_RAW) ? raw_value : throttle_next;
    sent_value = (value > cfg.max_throttle) ? cfg.max_throttle : value;
    frame = build_frame(sent_value, cfg.telemetry);
  end

endmodule
